[rtl/ltcd_pkg.sv]
// ----------------------------------------------------------------------------
// ltcd_pkg
// Shared types, constants and segment tables for the thermometer/clock display.
// ----------------------------------------------------------------------------
package ltcd_pkg;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TEMP_W  = 16;
	localparam int unsigned BTN_W   = 6;
	localparam int unsigned ADDR_W  = 6;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned WORDS   = 12;
	localparam int unsigned WORD_W  = $clog2(WORDS);
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MINT_W  = 11;
	localparam int unsigned DEC2_W  = 7;

	localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

	localparam logic [COUNT_W-1:0] LIMIT_SECONDS = 16'd43200;
	localparam logic [COUNT_W-1:0] SEC_PER_HOUR  = 16'd3600;
	localparam logic [COUNT_W-1:0] SEC_PER_MIN   = 16'd60;

	// exact floor division of any 16-bit value by reciprocal multiply
	localparam logic [16:0] HOUR_RECIP = 17'd74566;
	localparam int unsigned HOUR_SHIFT = 28;
	localparam logic [16:0] MIN_RECIP  = 17'd69906;
	localparam int unsigned MIN_SHIFT  = 22;

	// raw * 6.25 splits into raw / 16 (hundreds part) and 25 * (raw % 16) / 4
	localparam logic [11:0]       TEMP_SAT_WHOLE = 12'd100;
	localparam logic [DEC2_W-1:0] TEMP_SAT_PART  = 7'd99;
	localparam logic [8:0]        TEMP_FRAC_MUL  = 9'd25;

	localparam logic [NIB_W-1:0] SEG_DOT = 4'h2;

	localparam int unsigned BTN_SLEEP    = 0;
	localparam int unsigned BTN_TEMP     = 1;
	localparam int unsigned BTN_MIN_SEC  = 2;
	localparam int unsigned BTN_ADD_MIN  = 3;
	localparam int unsigned BTN_HOUR     = 4;
	localparam int unsigned BTN_ADD_HOUR = 5;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_BUTTONS = 2'd1,
		OP_REFRESH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_TEMP    = 2'd0,
		MODE_MIN_SEC = 2'd1,
		MODE_HOUR    = 2'd2
	} mode_t;

	// three nibbles of one digit, part 0 in the low bits
	function automatic logic [3*NIB_W-1:0] seg_plain(input logic [NIB_W-1:0] d);
		logic [3*NIB_W-1:0] s;
		case (d)
			4'd0, 4'd10: s = 12'hCAC;
			4'd1, 4'd11: s = 12'hC00;
			4'd2, 4'd12: s = 12'h8E4;
			4'd3, 4'd13: s = 12'hCE0;
			4'd4, 4'd14: s = 12'hC48;
			4'd5, 4'd15: s = 12'h4E8;
			4'd6:        s = 12'h4EC;
			4'd7:        s = 12'hC80;
			4'd8:        s = 12'hCEC;
			4'd9:        s = 12'hCE8;
			default:     s = '0;
		endcase
		return s;
	endfunction

	// tens and ones of a value below 128
	function automatic logic [2*NIB_W-1:0] split_dec(input logic [DEC2_W-1:0] v);
		logic [14:0]       p;
		logic [NIB_W-1:0]  tens;
		logic [DEC2_W-1:0] ones;
		p    = 15'(v) * 15'd205;
		tens = p[14:11];
		ones = v - 7'(7'(tens) * 7'd10);
		return {tens, ones[NIB_W-1:0]};
	endfunction

endpackage

[rtl/lcd_thermometer_clock_display_unit.sv]
// ----------------------------------------------------------------------------
// lcd_thermometer_clock_display_unit
// Refresh path: registered through stages s1 to s4, then loaded into the
// nibble shift register. Output: one word per cycle while m_tready is high;
// a refresh produces 12 words. Ticks and buttons update state when accepted.
// Reset: clears the seconds count, mode (temperature), sleep and all valids.
// ----------------------------------------------------------------------------
module lcd_thermometer_clock_display_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // buttons[5:0], temp_raw[21:6], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // lcd_address[5:0], segment_nibble[9:6], zero pad
	output logic        m_tlast
);
	import ltcd_pkg::*;

	logic [BTN_W-1:0]   buttons;
	logic [TEMP_W-1:0]  temp_raw;
	logic               in_fire, out_fire, push;

	logic [COUNT_W-1:0] count_q, count_d, val_d;
	mode_t              mode_q, mode_d;
	logic               asleep_q, asleep_d;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               en1, en2, en3, en4, ld, ser_free;

	logic [COUNT_W-1:0] val_s1;
	mode_t              mode_s1, mode_s2, mode_s3, mode_s4;

	logic [32:0]        hr_prod, min_prod;
	logic               temp_sat;
	logic [8:0]         frac_prod;
	logic [HOUR_W-1:0]  hr_s2;
	logic [MINT_W-1:0]  min_s2;
	logic [COUNT_W-1:0] cnt_s2;
	logic [DEC2_W-1:0]  thi_s2, tlo_s2;

	logic [MINT_W-1:0]  mn_wide;
	logic [COUNT_W-1:0] sc_wide;
	logic [DEC2_W-1:0]  hi_d, lo_d, hi_s3, lo_s3;

	logic [2*NIB_W-1:0] hi_dig, lo_dig;
	logic [NIB_W-1:0]   dig_s4 [4];

	logic [3*NIB_W-1:0] seg0, seg1, seg2, seg3;
	logic [WORDS*NIB_W-1:0] ser_d, ser_q;
	logic [WORD_W-1:0]  word_q;
	logic               busy_q;

	assign buttons  = s_tdata[BTN_W-1:0];
	assign temp_raw = s_tdata[BTN_W +: TEMP_W];

	// stall chain
	assign out_fire = m_tvalid && m_tready;
	assign ser_free = !busy_q || (out_fire && m_tlast);
	assign ld       = v_s4 && ser_free;
	assign en4      = !v_s4 || ld;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign in_fire  = s_tvalid && s_tready;
	assign push     = in_fire && (s_tuser == OP_REFRESH) && !asleep_q;

	// event state
	always_comb begin
		count_d  = count_q;
		mode_d   = mode_q;
		asleep_d = asleep_q;
		val_d    = temp_raw;
		case (s_tuser)
			OP_TICK: begin
				count_d = count_q + 16'd1;
			end
			OP_BUTTONS: begin
				count_d = count_q
					+ (buttons[BTN_ADD_MIN]  ? SEC_PER_MIN  : 16'd0)
					+ (buttons[BTN_ADD_HOUR] ? SEC_PER_HOUR : 16'd0);
				if (buttons[BTN_HOUR]) begin
					mode_d = MODE_HOUR;
				end else if (buttons[BTN_MIN_SEC]) begin
					mode_d = MODE_MIN_SEC;
				end else if (buttons[BTN_TEMP]) begin
					mode_d = MODE_TEMP;
				end
				if (buttons[BTN_TEMP] || buttons[BTN_MIN_SEC] || buttons[BTN_HOUR]) begin
					asleep_d = 1'b0;
				end else if (buttons[BTN_SLEEP]) begin
					asleep_d = 1'b1;
				end
			end
			OP_REFRESH: begin
				if (!asleep_q && (mode_q == MODE_MIN_SEC || mode_q == MODE_HOUR)) begin
					if (count_q > LIMIT_SECONDS) begin
						count_d = '0;
					end
					val_d = (count_q > LIMIT_SECONDS) ? '0 : count_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mode_q   <= MODE_TEMP;
			asleep_q <= 1'b0;
		end else if (in_fire) begin
			count_q  <= count_d;
			mode_q   <= mode_d;
			asleep_q <= asleep_d;
		end
	end

	// stage 2: hours, total minutes, temperature parts
	assign hr_prod   = 33'(val_s1) * 33'(HOUR_RECIP);
	assign min_prod  = 33'(val_s1) * 33'(MIN_RECIP);
	assign temp_sat  = val_s1[TEMP_W-1:4] >= TEMP_SAT_WHOLE;
	assign frac_prod = 9'(val_s1[3:0]) * TEMP_FRAC_MUL;

	// stage 3: minutes, seconds, select the two-digit pair
	assign mn_wide = min_s2 - 11'(11'(hr_s2) * 11'(SEC_PER_MIN));
	assign sc_wide = cnt_s2 - 16'(16'(min_s2) * SEC_PER_MIN);

	always_comb begin
		case (mode_s2)
			MODE_MIN_SEC: begin
				hi_d = mn_wide[DEC2_W-1:0];
				lo_d = sc_wide[DEC2_W-1:0];
			end
			MODE_HOUR: begin
				hi_d = DEC2_W'(hr_s2);
				lo_d = '0;
			end
			default: begin
				hi_d = thi_s2;
				lo_d = tlo_s2;
			end
		endcase
	end

	assign hi_dig = split_dec(hi_s3);
	assign lo_dig = split_dec(lo_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= push;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			val_s1  <= val_d;
			mode_s1 <= mode_q;
		end
		if (en2) begin
			mode_s2 <= mode_s1;
			hr_s2   <= hr_prod[HOUR_SHIFT +: HOUR_W];
			min_s2  <= min_prod[MIN_SHIFT +: MINT_W];
			cnt_s2  <= val_s1;
			thi_s2  <= temp_sat ? TEMP_SAT_PART : val_s1[4 +: DEC2_W];
			tlo_s2  <= temp_sat ? TEMP_SAT_PART : frac_prod[8:2];
		end
		if (en3) begin
			mode_s3 <= mode_s2;
			hi_s3   <= hi_d;
			lo_s3   <= lo_d;
		end
		if (en4) begin
			mode_s4   <= mode_s3;
			dig_s4[0] <= hi_dig[2*NIB_W-1:NIB_W];
			dig_s4[1] <= hi_dig[NIB_W-1:0];
			dig_s4[2] <= lo_dig[2*NIB_W-1:NIB_W];
			dig_s4[3] <= lo_dig[NIB_W-1:0];
		end
	end

	// nibble image, word 0 in the low bits
	assign seg0 = seg_plain(dig_s4[0]);
	assign seg1 = seg_plain(dig_s4[1]);
	assign seg2 = seg_plain(dig_s4[2]) | {SEG_DOT, 4'h0, SEG_DOT};
	assign seg3 = seg_plain(dig_s4[3]) | {SEG_DOT, 8'h00};

	always_comb begin
		case (mode_s4)
			MODE_HOUR: ser_d = {12'h000, seg1, seg0, 12'h000};
			default:   ser_d = {seg3, seg2, seg1, seg0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			word_q <= '0;
		end else if (ld) begin
			busy_q <= 1'b1;
			word_q <= '0;
		end else if (out_fire) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ser_q <= ser_d;
		end else if (out_fire) begin
			ser_q <= ser_q >> NIB_W;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = (word_q == LAST_WORD);
	assign m_tdata  = {6'b0, ser_q[NIB_W-1:0], 1'b0, word_q, 1'b1};

`ifndef SYNTHESIS
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> word_q <= LAST_WORD)
		else $error("word index past last word");

	a_sleep_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser == OP_REFRESH && asleep_q) |=> !v_s1)
		else $error("refresh entered pipeline while asleep");

	a_sec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && mode_s3 == MODE_MIN_SEC) |-> (lo_s3 < 7'd60 && hi_s3 < 7'd60))
		else $error("minutes or seconds out of range");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> (m_tvalid && word_q == '0))
		else $error("refresh burst did not start at first word");
`endif

endmodule
